// ----- design/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// Text sentence segmenter package
// Shared types and constants for the sentence segmenter blocks.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Width of one UTF-16 code unit.
   localparam int UNIT_W = 16;

   // Result queue depth and the widths that follow from it.
   localparam int QUEUE_DEPTH = 4;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Results that one request can cause.
   localparam int MAX_EMIT = 2;
   localparam int EMIT_W   = $clog2(MAX_EMIT + 1);

   // Classification of one code unit.
   typedef struct packed {
      logic punct;
      logic space;
      logic latin;
   } tss_class_type;

   // One result item.
   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              start;
      logic              latin;
      logic              last;
   } tss_result_type;

   // Results caused by one request, in delivery order.
   typedef struct packed {
      logic [EMIT_W-1:0] num;
      tss_result_type    first;
      tss_result_type    second;
   } tss_emit_type;

endpackage

// ----- design/tss_classify.sv -----
// ----------------------------------------------------------------------------
// Code unit classifier
// Sorts one UTF-16 code unit into punctuation, space or Latin letter/digit.
// ----------------------------------------------------------------------------
module tss_classify (
   input  logic [tss_pkg::UNIT_W-1:0] unit,
   output tss_pkg::tss_class_type     cls
);
   import tss_pkg::*;

   always_comb begin
      // Punctuation set, ASCII and CJK forms.
      case (unit)
         16'h002E, 16'h002C, 16'h0021, 16'h003F, 16'h003B, 16'h003A,
         16'h002D, 16'h0027, 16'h0022, 16'h0028, 16'h0029, 16'h005B,
         16'h005D, 16'h007B, 16'h007D,
         16'h3002, 16'hFF0C, 16'hFF01, 16'hFF1F, 16'hFF1B, 16'hFF1A,
         16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'hFF08, 16'hFF09,
         16'h3010, 16'h3011, 16'h300A, 16'h300B, 16'h3001, 16'h2014,
         16'h2026, 16'h00B7: cls.punct = 1'b1;
         default:            cls.punct = 1'b0;
      endcase

      // White space: controls, the typographic spaces and separators.
      cls.space = ((unit >= 16'h0009) && (unit <= 16'h000D)) ||
                  ((unit >= 16'h2000) && (unit <= 16'h200A)) ||
                  (unit == 16'h0020) || (unit == 16'h00A0) ||
                  (unit == 16'h2028) || (unit == 16'h2029) ||
                  (unit == 16'h202F) || (unit == 16'h205F) ||
                  (unit == 16'h3000);

      // Latin letters and decimal digits.
      cls.latin = ((unit >= 16'h0041) && (unit <= 16'h005A)) ||
                  ((unit >= 16'h0061) && (unit <= 16'h007A)) ||
                  ((unit >= 16'h0030) && (unit <= 16'h0039));
   end

endmodule

// ----- design/tss_core.sv -----
// ----------------------------------------------------------------------------
// Sentence state core
// Holds the sentence state and works out the results of one request.
// ----------------------------------------------------------------------------
module tss_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [tss_pkg::UNIT_W-1:0] unit,
   input  logic                       end_of_text,
   input  tss_pkg::tss_class_type     cls,
   output tss_pkg::tss_emit_type      emit
);
   import tss_pkg::*;

   logic              prev_latin_ff, prev_latin_in;
   logic              open_ff, open_in;
   logic              held_ff, held_in;
   logic [UNIT_W-1:0] held_unit_ff, held_unit_in;

   logic mode_change;
   logic open_eff;
   logic held_eff;

   // Next state and results for the current request.
   always_comb begin
      mode_change   = !cls.punct && !cls.space && (cls.latin != prev_latin_ff);
      open_eff      = open_ff && !mode_change;
      held_eff      = held_ff && !mode_change;
      prev_latin_in = prev_latin_ff;
      open_in       = open_ff;
      held_in       = held_ff;
      held_unit_in  = held_unit_ff;
      emit          = '0;

      if (cls.punct) begin
         // Punctuation closes the sentence.
         open_in      = 1'b0;
         held_in      = 1'b0;
         held_unit_in = '0;
      end else if (!cls.space) begin
         // A character: flush a held space, then the character itself.
         prev_latin_in = cls.latin;
         if (held_eff && open_eff) begin
            emit.num          = EMIT_W'(2);
            emit.first.unit   = held_unit_ff;
            emit.first.start  = 1'b0;
            emit.first.latin  = cls.latin;
            emit.first.last   = 1'b0;
            emit.second.unit  = unit;
            emit.second.start = 1'b0;
            emit.second.latin = cls.latin;
            emit.second.last  = 1'b1;
         end else begin
            emit.num         = EMIT_W'(1);
            emit.first.unit  = unit;
            emit.first.start = !open_eff;
            emit.first.latin = cls.latin;
            emit.first.last  = 1'b1;
         end
         open_in      = 1'b1;
         held_in      = 1'b0;
         held_unit_in = '0;
      end else if (!prev_latin_ff) begin
         // A space in other-script mode closes the sentence.
         open_in      = 1'b0;
         held_in      = 1'b0;
         held_unit_in = '0;
      end else if (open_ff && !held_ff) begin
         // First Latin space inside a sentence is held.
         held_in      = 1'b1;
         held_unit_in = unit;
      end

      // End of text returns everything to its reset values.
      if (end_of_text) begin
         prev_latin_in = 1'b0;
         open_in       = 1'b0;
         held_in       = 1'b0;
         held_unit_in  = '0;
      end
   end

   // State registers, updated when a request leaves the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_latin_ff <= 1'b0;
         open_ff       <= 1'b0;
         held_ff       <= 1'b0;
         held_unit_ff  <= '0;
      end else if (advance) begin
         prev_latin_ff <= prev_latin_in;
         open_ff       <= open_in;
         held_ff       <= held_in;
         held_unit_ff  <= held_unit_in;
      end
   end

endmodule

// ----- design/tss_outq.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Shift queue that takes up to two results per cycle and delivers one while the result side is ready.
// ----------------------------------------------------------------------------
module tss_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  tss_pkg::tss_emit_type  push,
   output logic                   room,
   output tss_pkg::tss_result_type head,
   output logic                   head_valid,
   input  logic                   pop_ready
);
   import tss_pkg::*;

   tss_result_type entry_ff [QUEUE_DEPTH];
   tss_result_type entry_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] base;
   logic             pop;

   // Room is judged on the registered count so that the result side's ready
   // never reaches the request side's ready in the same cycle.
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[0];
   assign pop        = head_valid && pop_ready;
   assign base       = count_ff - CNT_W'(pop);
   assign room       = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_EMIT));
   assign count_in   = base + CNT_W'(push.num);

   // Shift on a pop, then place new results behind the remaining ones.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            entry_in[i] = entry_ff[i + 1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if ((push.num != '0) && (CNT_W'(i) == base)) begin
            entry_in[i] = push.first;
         end
         if ((push.num == EMIT_W'(2)) && (CNT_W'(i) == base + CNT_W'(1))) begin
            entry_in[i] = push.second;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/text_sentence_segmenter_top.sv -----
// ----------------------------------------------------------------------------
// Text sentence segmenter
// Path: an accepted request waits in the input register; its results enter the
// result queue once the queue has room for two more and leave from its head.
// Throughput: one request per cycle while each request yields at most one
// result; the queue delivers one result per cycle; both need rsp_tready high.
// Reset: synchronous; clears the input stage, sentence state and result queue.
// Cuts a UTF-16 stream into sentences and flags each sentence's start.
// ----------------------------------------------------------------------------
module text_sentence_segmenter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_unit
   output logic [1:0]  rsp_tuser,   // [0] sentence_start, [1] latin_sentence
   output logic        rsp_tlast    // last_of_run
);
   import tss_pkg::*;

   logic              in_valid_ff;
   logic [UNIT_W-1:0] in_unit_ff;
   logic              in_eot_ff;
   logic              advance;
   logic              room;
   tss_class_type     cls;
   tss_emit_type      emit;
   tss_emit_type      push;
   tss_result_type    head;

   // Input stage moves on when the queue can hold two more results.
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   tss_classify u_classify (
      .unit (in_unit_ff),
      .cls  (cls)
   );

   tss_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .unit        (in_unit_ff),
      .end_of_text (in_eot_ff),
      .cls         (cls),
      .emit        (emit)
   );

   // Results enter the queue only with the request that caused them.
   always_comb begin
      push = emit;
      if (!advance) begin
         push.num = '0;
      end
   end

   tss_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head       (head),
      .head_valid (rsp_tvalid),
      .pop_ready  (rsp_tready)
   );

   assign rsp_tdata    = head.unit;
   assign rsp_tuser[0] = head.start;
   assign rsp_tuser[1] = head.latin;
   assign rsp_tlast    = head.last;

endmodule

// ----- design/tss_checker.sv -----
// ----------------------------------------------------------------------------
// Segmenter port checker
// Watches the result port for handshake and sentence consistency.
// ----------------------------------------------------------------------------
module tss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   logic seen_ff;
   logic last_latin_ff;
   logic rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Script of the last delivered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_latin_ff <= 1'b0;
      end else if (rsp_fire) begin
         seen_ff       <= 1'b1;
         last_latin_ff <= rsp_tuser[1];
      end
   end

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // A continued sentence keeps the script of the result before it.
   a_same_script: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_tuser[0] |-> seen_ff && (rsp_tuser[1] == last_latin_ff))
      else $error("sentence continued with a different script");

   // Full stop, comma and ideographic full stop never appear on the result port.
   a_no_punct: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 16'h002E) && (rsp_tdata != 16'h002C) &&
      (rsp_tdata != 16'h3002))
      else $error("punctuation delivered");

   // Other-script sentences carry no ASCII space.
   a_no_space: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> (rsp_tdata != 16'h0020))
      else $error("space in other-script sentence");

   // The first cycle out of reset shows an empty result port.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind text_sentence_segmenter_top tss_checker u_tss_checker (.*);
